/* rtl/sha512_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sha512_pkg;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } out_word_t;

  // One entry of the queue between front and back: a block word plus
  // a mark that closes the message after this word.
  typedef struct packed {
    logic [63:0] data;
    logic        final_word;
  } blk_word_t;

  localparam int unsigned QueueDepth = 4;

  localparam logic [63:0] PadWord = 64'h8000000000000000;

  function automatic logic [63:0] round_const(input logic [6:0] r);
    logic [63:0] k;
    begin
      unique case (r)
        7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
        7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
        7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
        7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
        7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
        7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
        7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
        7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
        7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
        7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
        7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
        7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
        7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
        7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
        7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
        7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
        7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
        7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
        7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
        7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
        7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
        7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
        7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
        7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
        7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
        7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
        7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
        7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
        7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
        7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
        7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
        7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
        7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
        7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
        7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
        7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
        7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
        7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
        7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
        7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
        default: k = 64'h0;
      endcase
      return k;
    end
  endfunction

  function automatic logic [63:0] init_value(input logic [2:0] i);
    logic [63:0] v;
    begin
      unique case (i)
        3'd0: v = 64'h6a09e667f3bcc908;
        3'd1: v = 64'hbb67ae8584caa73b;
        3'd2: v = 64'h3c6ef372fe94f82b;
        3'd3: v = 64'ha54ff53a5f1d36f1;
        3'd4: v = 64'h510e527fade682d1;
        3'd5: v = 64'h9b05688c2b3e6c1f;
        3'd6: v = 64'h1f83d9abfb41bd6b;
        default: v = 64'h5be0cd19137e2179;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/sha512_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// Takes message words, counts the length, and expands a last word into
// the full padding sequence of block words, one per cycle unless q_full.
module sha512_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sha512_pkg::in_word_t  in_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output sha512_pkg::blk_word_t      q_data,
  output logic                       q_push,
  input  wire logic                  q_full
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StPad   = 2'd1;
  localparam logic [1:0] StZero  = 2'd2;
  localparam logic [1:0] StSpill = 2'd3;

  localparam logic [63:0] PadShift = sha512_pkg::PadWord;

  logic [1:0]  state;
  logic [3:0]  pos;
  logic [63:0] bit_count;
  logic [3:0]  nbytes;
  logic [63:0] keep;
  logic [63:0] new_count;
  logic [63:0] word_out;
  logic        take;

  always_comb begin
    nbytes = (in_data.valid_bytes > 4'd8) ? 4'd8 : in_data.valid_bytes;
    keep = (nbytes == 4'd0) ? 64'h0 : ~(64'hffffffffffffffff >> {nbytes[3:0], 3'b000});
    if (!in_data.last_word) begin
      new_count = bit_count + 64'd64;
    end else begin
      new_count = bit_count + {57'd0, nbytes, 3'b000};
    end
    if (nbytes == 4'd8 || !in_data.last_word) begin
      word_out = in_data.message_word;
    end else begin
      word_out = (in_data.message_word & keep) | (PadShift >> {nbytes[2:0], 3'b000});
    end
  end

  assign in_stall = (state != StIdle) || q_full;
  assign take = in_valid && !in_stall;

  always_comb begin
    q_push = 1'b0;
    q_data = '{data: 64'h0, final_word: 1'b0};
    unique case (state)
      StIdle: begin
        q_push = take;
        q_data.data = word_out;
      end
      StPad: begin
        q_push = !q_full;
        q_data.data = PadShift;
      end
      StZero: begin
        q_push = !q_full;
        q_data.data = (pos == 4'd15) ? bit_count : 64'h0;
        q_data.final_word = (pos == 4'd15);
      end
      default: begin
        // A zero word that closes a block with no room for the length.
        q_push = !q_full;
        q_data.data = 64'h0;
      end
    endcase
  end

  // After each pushed word, decide what follows: positions 14 and 15 carry
  // the length, so a pad word that lands at 14 or 15 spills to a new block.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      pos <= 4'd0;
      bit_count <= 64'd0;
    end else if (q_push) begin
      pos <= pos + 4'd1;
      unique case (state)
        StIdle: begin
          bit_count <= new_count;
          if (in_data.last_word) begin
            if (nbytes == 4'd8) begin
              state <= StPad;
            end else if (pos == 4'd14) begin
              state <= StSpill;
            end else begin
              state <= StZero;
            end
          end
        end
        StPad: state <= (pos == 4'd14) ? StSpill : StZero;
        StZero: begin
          if (pos == 4'd15) begin
            state <= StIdle;
            pos <= 4'd0;
            bit_count <= 64'd0;
          end
        end
        default: begin
          state <= StZero;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/sha512_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module sha512_queue #(
  parameter int unsigned Depth = sha512_pkg::QueueDepth
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sha512_pkg::blk_word_t push_data,
  input  wire logic                 push,
  output logic                      full,
  output sha512_pkg::blk_word_t     pop_data,
  input  wire logic                 pop,
  output logic                      not_empty
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha512_pkg::blk_word_t slots [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full = (count == (AW+1)'(Depth));
  assign not_empty = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/sha512_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// Gathers block words, runs 80 rounds per full block with a 16-word rolling
// schedule, and sends the digest after a closing block.
module sha512_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sha512_pkg::blk_word_t q_data,
  input  wire logic                  q_avail,
  output logic                       q_pop,
  output sha512_pkg::out_word_t      out_data,
  output logic                       out_valid,
  input  wire logic                  out_stall
);

  localparam logic [1:0] StFill  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StAdd   = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  logic [1:0]  state;
  logic [3:0]  fill;
  logic [6:0]  rnd;
  logic        closing;
  logic [2:0]  oidx;
  logic [63:0] w [16];
  logic [63:0] h [8];
  logic [63:0] va [8];

  logic [63:0] s1, ch, s0, maj, t1, t2, wt, wnew, x2, x15;

  function automatic logic [63:0] rr(input logic [63:0] v, input int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  always_comb begin
    x2 = w[14];
    x15 = w[1];
    wnew = (rr(x2, 19) ^ rr(x2, 61) ^ (x2 >> 6)) + w[9]
         + (rr(x15, 1) ^ rr(x15, 8) ^ (x15 >> 7)) + w[0];
    wt = w[0];
    s1 = rr(va[4], 14) ^ rr(va[4], 18) ^ rr(va[4], 41);
    ch = (va[4] & va[5]) ^ (~va[4] & va[6]);
    s0 = rr(va[0], 28) ^ rr(va[0], 34) ^ rr(va[0], 39);
    maj = (va[0] & va[1]) ^ (va[0] & va[2]) ^ (va[1] & va[2]);
    t1 = va[7] + s1 + ch + sha512_pkg::round_const(rnd) + wt;
    t2 = s0 + maj;
  end

  assign q_pop = (state == StFill) && q_avail;
  assign out_valid = (state == StOut);
  assign out_data = '{digest_word: h[oidx], digest_index: oidx,
                      digest_last: (oidx == 3'd7)};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w[fill] <= q_data.data;
    end else if (state == StRound) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (state == StFill) begin
      for (int i = 0; i < 8; i++) begin
        va[i] <= h[i];
      end
    end else if (state == StRound) begin
      for (int i = 1; i < 8; i++) begin
        va[i] <= va[i - 1];
      end
      va[4] <= va[3] + t1;
      va[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StFill;
      fill <= 4'd0;
      rnd <= 7'd0;
      closing <= 1'b0;
      oidx <= 3'd0;
      for (int i = 0; i < 8; i++) begin
        h[i] <= sha512_pkg::init_value(3'(i));
      end
    end else begin
      unique case (state)
        StFill: begin
          if (q_pop) begin
            fill <= fill + 4'd1;
            if (fill == 4'd15) begin
              closing <= q_data.final_word;
              rnd <= 7'd0;
              state <= StRound;
            end
          end
        end
        StRound: begin
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) begin
            state <= StAdd;
          end
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= h[i] + va[i];
          end
          state <= closing ? StOut : StFill;
          oidx <= 3'd0;
        end
        default: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state <= StFill;
              for (int i = 0; i < 8; i++) begin
                h[i] <= sha512_pkg::init_value(3'(i));
              end
            end
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/sha512_hasher.sv */
`timescale 1ns / 1ps
`default_nettype none
// SHA-512 hasher. Message words arrive big-endian, eight bytes each; the
// final word carries last_word and a count of its leading valid bytes. A
// front stage counts the length and expands the final word into padding and
// the 128-bit length, pushing one block word per cycle into a four-word
// queue while it is not full. The back stage gathers sixteen words, runs the
// 80 rounds at one per cycle, then folds the result into the chain value, so
// the sustained rate is set by the single round unit. After the closing block
// the eight digest words leave in order, index 0 first, digest_last on the
// eighth, and the chain value returns to the initial hash values.
module sha512_hasher #(
  parameter int unsigned QueueDepth = sha512_pkg::QueueDepth
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sha512_pkg::in_word_t  in_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output sha512_pkg::out_word_t      out_data,
  output logic                       out_valid,
  input  wire logic                  out_stall
);

  sha512_pkg::blk_word_t push_word;
  sha512_pkg::blk_word_t pop_word;
  logic push, full, pop, avail;

  sha512_front u_front (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid),
    .in_stall(in_stall), .q_data(push_word), .q_push(push), .q_full(full)
  );

  sha512_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .push_data(push_word), .push(push), .full(full),
    .pop_data(pop_word), .pop(pop), .not_empty(avail)
  );

  sha512_back u_back (
    .clk(clk), .rst(rst), .q_data(pop_word), .q_avail(avail), .q_pop(pop),
    .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
  );

endmodule
`default_nettype wire

/* rtl/sha512_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module sha512_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire sha512_pkg::in_word_t  in_data,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire sha512_pkg::out_word_t out_data,
  input wire logic                  out_valid,
  input wire logic                  out_stall
);

  // In order: each taken digest word but the last is followed by the next one.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.digest_last |=>
      out_valid && (out_data.digest_index == $past(out_data.digest_index) + 3'd1))
    else $error("digest index skipped");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.digest_last == (out_data.digest_index == 3'd7)))
    else $error("digest_last mismatch");

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (out_data.digest_index == 3'd0))
    else $error("digest does not start at index 0");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled digest word changed");

  // A message word held off by the block waits unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled message word changed");

endmodule

bind sha512_hasher sha512_checker u_checker (
  .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid),
  .in_stall(in_stall), .out_data(out_data), .out_valid(out_valid),
  .out_stall(out_stall)
);
`default_nettype wire

/* verif/sha512_hasher_tb.sv */
`timescale 1ns / 1ps
module sha512_hasher_tb;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned BlockCycles = 97;

  logic clk = 1'b0;
  logic rst = 1'b1;
  sha512_pkg::in_word_t in_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  sha512_pkg::out_word_t out_data;
  logic out_valid;
  logic out_stall = 1'b0;

  // The receiver idles at random unless it is told to stay quiet, and it can
  // be held off entirely for a counted stretch to fill the block's queue.
  bit sink_quiet = 1'b0;
  int unsigned hold_cycles = 0;
  bit source_quiet = 1'b0;

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned digests_seen = 0;
  int unsigned messages_sent = 0;

  // The testbench's own copy of the hash state.
  logic [63:0] model_chain[8];
  logic [63:0] model_block[16];
  int unsigned model_held;
  logic [63:0] model_bits;

  // Digest words still owed by the block, oldest first.
  sha512_pkg::out_word_t digest_queue[$];

  sha512_hasher DUT (
    .clk(clk),
    .rst(rst),
    .in_data(in_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_data(out_data),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Round constants, kept locally so that the prediction stands on its own.
  localparam logic [63:0] RoundK[80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] StartChain[8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  // Eighty rounds over the sixteen held words, folded into the chain.
  task automatic compress_model();
    logic [63:0] w[80];
    logic [63:0] s[8];
    logic [63:0] t1, t2;
    for (int r = 0; r < 16; r++) w[r] = model_block[r];
    for (int r = 16; r < 80; r++) begin
      w[r] = (rotr(w[r-2], 19) ^ rotr(w[r-2], 61) ^ (w[r-2] >> 6)) + w[r-7]
           + (rotr(w[r-15], 1) ^ rotr(w[r-15], 8) ^ (w[r-15] >> 7)) + w[r-16];
    end
    for (int i = 0; i < 8; i++) s[i] = model_chain[i];
    for (int r = 0; r < 80; r++) begin
      t1 = s[7] + (rotr(s[4], 14) ^ rotr(s[4], 18) ^ rotr(s[4], 41))
         + ((s[4] & s[5]) ^ (~s[4] & s[6])) + RoundK[r] + w[r];
      t2 = (rotr(s[0], 28) ^ rotr(s[0], 34) ^ rotr(s[0], 39))
         + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
      s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
      s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) model_chain[i] += s[i];
  endtask

  task automatic append_block_word(input logic [63:0] v);
    model_block[model_held] = v;
    model_held++;
    if (model_held == 16) begin
      compress_model();
      model_held = 0;
    end
  endtask

  task automatic hash_reset_model();
    for (int i = 0; i < 8; i++) model_chain[i] = StartChain[i];
    model_held = 0;
    model_bits = '0;
  endtask

  // Advance the predicted hash by one accepted word; on a last word the
  // padding is applied and the eight digest words are queued.
  task automatic predict_digest(input sha512_pkg::in_word_t w);
    int unsigned n;
    logic [63:0] keep;
    sha512_pkg::out_word_t d;
    if (!w.last_word) begin
      model_bits += 64;
      append_block_word(w.message_word);
      return;
    end
    n = (w.valid_bytes > 8) ? 8 : w.valid_bytes;
    model_bits += 64'(n * 8);
    if (n == 8) begin
      append_block_word(w.message_word);
      append_block_word(64'h8000000000000000);
    end else begin
      keep = (n == 0) ? 64'h0 : ~64'h0 << (64 - 8 * n);
      append_block_word((w.message_word & keep) | (64'h80 << (56 - 8 * n)));
    end
    // The length needs the last two words of a block.
    if (model_held > 14) begin
      while (model_held != 0) append_block_word('0);
    end
    while (model_held < 14) append_block_word('0);
    append_block_word('0);
    append_block_word(model_bits);
    for (int j = 0; j < 8; j++) begin
      d.digest_word = model_chain[j];
      d.digest_index = 3'(j);
      d.digest_last = (j == 7);
      digest_queue = {digest_queue, d};
    end
    hash_reset_model();
  endtask

  // Offer one word and hold it until the block takes it; the prediction is
  // updated at the accepting edge. Valid drops only while the sender idles.
  task automatic send_word(input logic [63:0] data, input logic [3:0] nbytes,
                           input logic last);
    sha512_pkg::in_word_t w;
    w.message_word = data;
    w.valid_bytes = nbytes;
    w.last_word = last;
    while (!source_quiet && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_digest(w);
    words_sent++;
    if (last) messages_sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A message of the given number of full words followed by a last word.
  task automatic send_message(input int unsigned full_words, input logic [3:0] nbytes);
    for (int i = 0; i < full_words; i++) send_word(rand64(), 4'd8, 1'b0);
    send_word(rand64(), nbytes, 1'b1);
  endtask

  // Receiver stall pattern: random idling, a quiet stretch, or a long hold.
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (sink_quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 27);
    end
  end

  // Compare every accepted digest word with the oldest prediction.
  always @(posedge clk) begin
    sha512_pkg::out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      digests_seen++;
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d last %0b", $time,
                 out_data.digest_word, out_data.digest_index, out_data.digest_last);
        errors++;
      end else begin
        want = digest_queue.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $time,
                   want.digest_word, out_data.digest_word);
          errors++;
        end
        if (out_data.digest_index !== want.digest_index) begin
          $display("%0t: digest_index expected %0d actual %0d", $time,
                   want.digest_index, out_data.digest_index);
          errors++;
        end
        if (out_data.digest_last !== want.digest_last) begin
          $display("%0t: digest_last expected %0b actual %0b", $time,
                   want.digest_last, out_data.digest_last);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Known digests of short messages, then padding corner cases: every valid
  // byte count, counts above eight, an empty last word, and last words that
  // land where the length no longer fits so that an extra block is needed.
  task automatic test_directed();
    send_word(64'h6162630000000000, 4'd3, 1'b1);   // "abc"
    send_word(64'h0, 4'd0, 1'b1);                   // empty message
    for (int n = 0; n <= 15; n++) send_word(rand64(), 4'(n), 1'b1);
    send_word(64'hffffffffffffffff, 4'd7, 1'b1);
    send_message(14, 4'd8);   // pad word closes the block exactly
    send_message(14, 4'd0);   // padding in the fifteenth slot
  endtask

  // Short words that are not marked last count as full words.
  task automatic test_short_not_last();
    send_word(64'hffffffffffffffff, 4'd0, 1'b0);
    send_word(64'h0123456789abcdef, 4'd3, 1'b0);
    send_word(64'h0, 4'd15, 1'b1);
  endtask

  // Hold the receiver off while words keep flowing, so that the block fills
  // its queue and stalls its input; digests back up behind the hold.
  task automatic test_backpressure();
    hold_cycles = 1500;
    send_message(2, 4'd5);
    send_message(20, 4'd8);
    send_message(1, 4'd2);
  endtask

  // Mostly well-formed messages of random length and content; lengths stay
  // small with a few long ones so that several blocks chain together.
  task automatic test_random();
    int unsigned len;
    while (words_sent < 190) begin
      if (words_sent > 120 && words_sent < 170) begin
        source_quiet = 1'b1;
        sink_quiet = 1'b1;
      end else begin
        source_quiet = 1'b0;
        sink_quiet = 1'b0;
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(15);
      send_message(len, 4'($urandom_range(15)));
    end
    source_quiet = 1'b0;
    sink_quiet = 1'b0;
  endtask

  initial begin
    hash_reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_short_not_last();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (2 * BlockCycles) @(posedge clk);
    $display("Sent %0d words in %0d messages; checked %0d digest words.",
             words_sent, messages_sent, digests_seen);
    $display("Covered all byte counts, extra padding blocks and a long output hold.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sha512_pkg.sv
rtl/sha512_front.sv
rtl/sha512_queue.sv
rtl/sha512_back.sv
rtl/sha512_hasher.sv
rtl/sha512_checker.sv
verif/sha512_hasher_tb.sv
